/* src/ctb_pkg.sv */
// ----------------------------------------------------------------------------
// ctb_pkg: shared definitions for the countdown timer bank
// Operation codes, slot modes, control state codes and the structs that
// travel between the top level and the row of timer cells.
// ----------------------------------------------------------------------------
package ctb_pkg;

   // Bank size (at most 64 so that every slot index fits the slot field).
   localparam int NUM_TIMERS = 16;

   // Field widths.
   localparam int OP_W    = 3;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 32;
   localparam int TAG_W   = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_COUNT = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_TAG   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK      = 3'd4;
   localparam logic [OP_W-1:0] OP_SERVICE   = 3'd5;

   // Result kinds.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // Per-slot mode.
   typedef enum logic [1:0] {
      MODE_FREE      = 2'd0,
      MODE_ALLOCATED = 2'd1,
      MODE_COUNTING  = 2'd2
   } mode_type;

   // Top-level control states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Command broadcast from the top level to every cell.
   typedef struct packed {
      logic               write;
      logic               start;
      logic               advance;
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] ticks;
   } cmd_type;

   // Status handed from each cell to its neighbor.
   typedef struct packed {
      logic              free_seen;
      logic              usable;
      logic              expire;
      logic [SLOT_W-1:0] pick_slot;
      logic [TAG_W-1:0]  pick_tag;
   } chain_type;

endpackage

/* src/ctb_cell.sv */
// ----------------------------------------------------------------------------
// ctb_cell: one timer slot
// Holds the mode, remaining count and tag of one slot, answers the status
// chain for allocate and addressed operations, and services its own count
// when the service token sits in it.
// ----------------------------------------------------------------------------
module ctb_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ctb_pkg::SLOT_W-1:0] cell_id,
   input  ctb_pkg::cmd_type           cmd,
   input  logic                       tok_in,
   output logic                       tok_out,
   input  ctb_pkg::chain_type         chain_in,
   output ctb_pkg::chain_type         chain_out
);
   import ctb_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               tok_ff, tok_in_nx;

   logic is_free;
   logic first_free;
   logic mine;
   logic in_use;
   logic hit;
   logic expires;

   assign is_free    = (mode_ff == MODE_FREE);
   assign first_free = is_free && !chain_in.free_seen;
   assign mine       = (cmd.slot == cell_id);
   assign in_use     = mine && !is_free;
   assign hit        = tok_ff && (mode_ff == MODE_COUNTING);
   assign expires    = hit && (rem_ff <= cmd.ticks);

   // Status chain toward the next cell. An expiring slot upstream keeps its
   // index, so a later free slot cannot take over the picked slot.
   always_comb begin
      chain_out.free_seen = chain_in.free_seen || is_free;
      chain_out.usable    = chain_in.usable || in_use;
      chain_out.expire    = chain_in.expire || expires;
      chain_out.pick_slot = (tok_ff || (first_free && !chain_in.expire)) ?
                            cell_id : chain_in.pick_slot;
      chain_out.pick_tag  = tok_ff ? tag_ff : chain_in.pick_tag;
   end

   assign tok_out = tok_ff;

   // Next state of the slot.
   always_comb begin
      mode_in   = mode_ff;
      rem_in    = rem_ff;
      tag_in    = tag_ff;
      tok_in_nx = tok_ff;
      if (cmd.start || cmd.advance) begin
         tok_in_nx = tok_in;
      end
      if (cmd.write) begin
         case (cmd.op)
            OP_ALLOC: begin
               if (first_free) begin
                  mode_in = MODE_ALLOCATED;
                  rem_in  = '0;
                  tag_in  = cmd.tag;
               end
            end
            OP_FREE: begin
               if (in_use) begin
                  mode_in = MODE_FREE;
                  rem_in  = '0;
                  tag_in  = '0;
               end
            end
            OP_SET_COUNT: begin
               if (in_use && (cmd.count != '0)) begin
                  mode_in = MODE_COUNTING;
                  rem_in  = cmd.count;
               end
            end
            OP_SET_TAG: begin
               if (in_use) begin
                  tag_in = cmd.tag;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.advance && hit) begin
         if (expires) begin
            mode_in = MODE_ALLOCATED;
            rem_in  = '0;
         end else begin
            rem_in = rem_ff - cmd.ticks;
         end
      end
   end

   // Slot registers; only the mode and token need a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FREE;
         tok_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         tok_ff  <= tok_in_nx;
      end
      rem_ff <= rem_in;
      tag_ff <= tag_in;
   end

endmodule

/* src/countdown_timer_bank.sv */
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of one-shot countdown timers
// A row of timer cells with a status chain, a service token that walks the
// row, a pending-tick accumulator and a registered result word.
// ----------------------------------------------------------------------------
// Allocate, free, set count, set tag, tick and unknown operations each give
// one status word. During a service a token walks the row of cells one slot
// per cycle, each expired slot gives an expiry word as the token passes, and
// a final status word closes the service. A stall on the result side holds
// the walk. A new request word is taken only while no service is in
// progress and the result register is empty or being emptied in the same cycle.
module countdown_timer_bank (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ctb_pkg::OP_W-1:0]    req_operation,
   input  logic [ctb_pkg::SLOT_W-1:0]  req_slot,
   input  logic [ctb_pkg::COUNT_W-1:0] req_start_count,
   input  logic [ctb_pkg::TAG_W-1:0]   req_tag_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic                        rsp_error,
   output logic [ctb_pkg::SLOT_W-1:0]  rsp_slot_out,
   output logic [ctb_pkg::TAG_W-1:0]   rsp_tag_out,
   output logic                        rsp_last
);
   import ctb_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] pending_ff, pending_in;
   logic [COUNT_W-1:0] ticks_ff, ticks_in;

   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic               error_ff, error_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               last_ff, last_in;

   logic      out_free;
   logic      accept;
   cmd_type   cmd;
   chain_type chain_link [NUM_TIMERS+1];
   logic      tok_link   [NUM_TIMERS+1];
   chain_type chain_end;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Command broadcast to the cells.
   always_comb begin
      cmd.write   = accept && (req_operation != OP_SERVICE);
      cmd.start   = accept && (req_operation == OP_SERVICE);
      cmd.advance = (state_ff == ST_WALK) && out_free;
      cmd.op      = req_operation;
      cmd.slot    = req_slot;
      cmd.count   = req_start_count;
      cmd.tag     = req_tag_in;
      cmd.ticks   = ticks_ff;
   end

   // Row of timer cells.
   assign chain_link[0] = '0;
   assign tok_link[0]   = cmd.start;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      ctb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (SLOT_W'(g)),
         .cmd       (cmd),
         .tok_in    (tok_link[g]),
         .tok_out   (tok_link[g+1]),
         .chain_in  (chain_link[g]),
         .chain_out (chain_link[g+1])
      );
   end

   assign chain_end = chain_link[NUM_TIMERS];

   // Control, accumulator and result word.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      ticks_in   = ticks_ff;
      valid_in   = valid_ff && !rsp_ready;
      kind_in    = kind_ff;
      error_in   = error_ff;
      slot_in    = slot_ff;
      tag_in     = tag_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_SERVICE) begin
                  ticks_in   = pending_ff;
                  pending_in = '0;
                  state_in   = ST_WALK;
               end else begin
                  valid_in = 1'b1;
                  kind_in  = KIND_STATUS;
                  error_in = 1'b0;
                  slot_in  = '0;
                  tag_in   = '0;
                  last_in  = 1'b1;
                  case (req_operation)
                     OP_ALLOC: begin
                        error_in = !chain_end.free_seen;
                        slot_in  = chain_end.free_seen ? chain_end.pick_slot : '0;
                     end
                     OP_FREE, OP_SET_TAG: begin
                        error_in = !chain_end.usable;
                     end
                     OP_SET_COUNT: begin
                        error_in = !chain_end.usable || (req_start_count == '0);
                     end
                     OP_TICK: begin
                        if (pending_ff != '1) begin
                           pending_in = pending_ff + COUNT_W'(1);
                        end
                     end
                     default: begin
                        error_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (cmd.advance) begin
               if (chain_end.expire) begin
                  valid_in = 1'b1;
                  kind_in  = KIND_EXPIRY;
                  error_in = 1'b0;
                  slot_in  = chain_end.pick_slot;
                  tag_in   = chain_end.pick_tag;
                  last_in  = 1'b0;
               end
               if (tok_link[NUM_TIMERS]) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_STATUS;
               error_in = 1'b0;
               slot_in  = '0;
               tag_in   = '0;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
      ticks_ff <= ticks_in;
      kind_ff  <= kind_in;
      error_ff <= error_in;
      slot_ff  <= slot_in;
      tag_ff   <= tag_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_error    = error_ff;
   assign rsp_slot_out = slot_ff;
   assign rsp_tag_out  = tag_ff;
   assign rsp_last     = last_ff;

endmodule

/* bench/tb_countdown_timer_bank.sv */
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank: self-checking bench for the countdown timer bank
// Drives request words through the valid/ready channel and keeps a shadow
// copy of the timer slots, the tags and the tick accumulator. Every response
// word is checked field by field against the oldest predicted word. A short
// directed table comes first, then a long run of random traffic with idle
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank;
   import ctb_pkg::*;

   // Operation codes the block does not implement.
   localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

   localparam int  HALF_PERIOD    = 4;
   localparam int  RESET_CYCLES   = 4;
   localparam int  RANDOM_WORDS   = 220;
   localparam int  SERVICE_CYCLES = NUM_TIMERS + 2;
   localparam int  LONG_HOLD      = 250;
   localparam int  HOLD_AFTER     = 60;
   localparam int  MAX_REPORTS    = 10;
   localparam longint TIMEOUT_CYCLES = 1000000;

   // One response word, in port order.
   typedef struct packed {
      logic              kind;
      logic              error;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } timer_word_type;

   // One row of the directed table; typed rows carry their own answer.
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   tag;
      logic               typed;
      timer_word_type     want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation;
   logic [SLOT_W-1:0]   req_slot;
   logic [COUNT_W-1:0]  req_start_count;
   logic [TAG_W-1:0]    req_tag_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_kind;
   logic                rsp_error;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic                rsp_last;

   // Shadow state of the timer bank.
   mode_type            tmr_mode [NUM_TIMERS];
   logic [COUNT_W-1:0]  tmr_left [NUM_TIMERS];
   logic [TAG_W-1:0]    tmr_tag [NUM_TIMERS];
   logic [COUNT_W-1:0]  tick_acc;

   timer_word_type      op_words[$];
   timer_word_type      awaited_words[$];
   int                  mismatch_count = 0;
   int                  words_seen = 0;
   bit                  rsp_taken = 1'b0;
   bit                  steady_phase = 1'b0;

   countdown_timer_bank i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_slot        (req_slot),
      .req_start_count (req_start_count),
      .req_tag_in      (req_tag_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_error       (rsp_error),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_last        (rsp_last)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // A status word closes every operation; only allocate reports a slot.
   function automatic timer_word_type status_word(input logic err,
                                                  input logic [SLOT_W-1:0] slot);
      return '{KIND_STATUS, err, slot, '0, 1'b1};
   endfunction

   // Apply one accepted request to the shadow state and list its words.
   function automatic void apply_timer_op(input logic [OP_W-1:0] op,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [COUNT_W-1:0] count,
                                          input logic [TAG_W-1:0] tag);
      logic               usable;
      logic               found;
      logic [COUNT_W-1:0] taken;
      int                 i;
      op_words.delete();
      usable = 1'b0;
      if (slot < NUM_TIMERS) begin
         usable = (tmr_mode[slot] != MODE_FREE);
      end
      case (op)
         OP_ALLOC: begin
            found = 1'b0;
            for (i = 0; i < NUM_TIMERS; i++) begin
               if (!found && tmr_mode[i] == MODE_FREE) begin
                  found       = 1'b1;
                  tmr_mode[i] = MODE_ALLOCATED;
                  tmr_tag[i]  = tag;
                  tmr_left[i] = '0;
                  op_words.push_back(status_word(1'b0, SLOT_W'(i)));
               end
            end
            // Bank full.
            if (!found) begin
               op_words.push_back(status_word(1'b1, '0));
            end
         end
         OP_FREE: begin
            if (!usable) begin
               op_words.push_back(status_word(1'b1, '0));
            end else begin
               tmr_mode[slot] = MODE_FREE;
               tmr_left[slot] = '0;
               tmr_tag[slot]  = '0;
               op_words.push_back(status_word(1'b0, '0));
            end
         end
         OP_SET_COUNT: begin
            if (count == '0 || !usable) begin
               op_words.push_back(status_word(1'b1, '0));
            end else begin
               tmr_left[slot] = count;
               tmr_mode[slot] = MODE_COUNTING;
               op_words.push_back(status_word(1'b0, '0));
            end
         end
         OP_SET_TAG: begin
            if (!usable) begin
               op_words.push_back(status_word(1'b1, '0));
            end else begin
               tmr_tag[slot] = tag;
               op_words.push_back(status_word(1'b0, '0));
            end
         end
         OP_TICK: begin
            // The accumulator saturates rather than wrapping.
            if (tick_acc != '1) begin
               tick_acc = tick_acc + 1'b1;
            end
            op_words.push_back(status_word(1'b0, '0));
         end
         OP_SERVICE: begin
            taken    = tick_acc;
            tick_acc = '0;
            for (i = 0; i < NUM_TIMERS; i++) begin
               if (tmr_mode[i] == MODE_COUNTING) begin
                  if (tmr_left[i] > taken) begin
                     tmr_left[i] = tmr_left[i] - taken;
                  end else begin
                     // Expired: the slot stays allocated but stops counting.
                     tmr_left[i] = '0;
                     tmr_mode[i] = MODE_ALLOCATED;
                     op_words.push_back('{KIND_EXPIRY, 1'b0, SLOT_W'(i), tmr_tag[i], 1'b0});
                  end
               end
            end
            op_words.push_back(status_word(1'b0, '0));
         end
         default: begin
            op_words.push_back(status_word(1'b1, '0));
         end
      endcase
   endfunction

   // Idle gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (steady_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   // Slot field: mostly a slot in use, sometimes any slot, sometimes any field value.
   function automatic logic [SLOT_W-1:0] pick_slot();
      int live[$];
      int r;
      int i;
      r = $urandom_range(0, 99);
      for (i = 0; i < NUM_TIMERS; i++) begin
         if (tmr_mode[i] != MODE_FREE) begin
            live.push_back(i);
         end
      end
      if (r < 75 && live.size() > 0) begin
         return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
      end
      if (r < 90) begin
         return SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      end
      return SLOT_W'($urandom_range(0, 63));
   endfunction

   // Counts are mostly small so that timers expire within a few services.
   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return COUNT_W'($urandom_range(1, 5));
      end
      if (r < 82) begin
         return $urandom;
      end
      if (r < 92) begin
         return '0;
      end
      return COUNT_W'($urandom_range(6, 40));
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: wrong %s, expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // Offer one request word, hold it until taken, then predict its answer.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [COUNT_W-1:0] count, input logic [TAG_W-1:0] tag,
                            input logic typed, input timer_word_type want);
      logic ready_seen;
      int   gap;
      int   i;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_slot        <= slot;
      req_start_count <= count;
      req_tag_in      <= tag;
      // Ready is stable at the falling edge, ahead of the accepting edge.
      do begin
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end while (!ready_seen);
      apply_timer_op(op, slot, count, tag);
      if (typed) begin
         awaited_words.push_back(want);
      end else begin
         for (i = 0; i < op_words.size(); i++) begin
            awaited_words.push_back(op_words[i]);
         end
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Check each response word as it is taken.
   always @(negedge clock) begin : check_words
      timer_word_type got;
      timer_word_type want;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (rsp_taken) begin
         words_seen++;
         got = {rsp_kind, rsp_error, rsp_slot_out, rsp_tag_out, rsp_last};
         if (awaited_words.size() == 0) begin
            report_mismatch("word with none awaited, tag", '0, got.tag);
         end else begin
            want = awaited_words.pop_front();
            if (got.kind !== want.kind) begin
               report_mismatch("kind", 32'(want.kind), 32'(got.kind));
            end
            if (got.error !== want.error) begin
               report_mismatch("error", 32'(want.error), 32'(got.error));
            end
            if (got.slot !== want.slot) begin
               report_mismatch("slot_out", 32'(want.slot), 32'(got.slot));
            end
            if (got.tag !== want.tag) report_mismatch("tag_out", want.tag, got.tag);
            if (got.last !== want.last) begin
               report_mismatch("last", 32'(want.last), 32'(got.last));
            end
         end
      end
   end

   // Response side: random stalls, plus one long hold-off to back up the block.
   initial begin
      int gap_left;
      bit long_hold_done;
      gap_left       = 0;
      long_hold_done = 1'b0;
      rsp_ready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && words_seen >= HOLD_AFTER) begin
            gap_left       = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (rsp_taken && gap_left == 0) begin
            gap_left = pick_gap();
         end
         rsp_ready <= (gap_left == 0);
         if (gap_left > 0) begin
            gap_left--;
         end
      end
   end

   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("Mismatches found");
      $finish;
   end

   // Request side: directed table, then random traffic.
   initial begin
      stim_row_type       plan[$];
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   tag;
      int                 n;
      int                 r;
      int                 i;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_ALLOC;
      req_slot        <= '0;
      req_start_count <= '0;
      req_tag_in      <= '0;
      for (i = 0; i < NUM_TIMERS; i++) begin
         tmr_mode[i] = MODE_FREE;
         tmr_left[i] = '0;
         tmr_tag[i]  = '0;
      end
      tick_acc = '0;

      // Directed table: op, slot, count, tag, typed, answer.
      // Nothing is armed after reset, so service only closes.
      plan.push_back('{OP_SERVICE,   6'd0,  32'd0,         32'd0,         1'b1,
                       status_word(1'b0, 6'd0)});
      plan.push_back('{OP_TICK,      6'd0,  32'd0,         32'd0,         1'b1,
                       status_word(1'b0, 6'd0)});
      // Free slots, an out-of-range slot and unknown operations are rejected.
      plan.push_back('{OP_FREE,      6'd0,  32'd0,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_SET_COUNT, 6'd5,  32'd9,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_SET_TAG,   6'd63, 32'd0,         32'hFFFF_FFFF, 1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_BAD_LO,    6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_BAD_HI,    6'd0,  32'd0,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      // Allocation hands out the lowest free slots.
      plan.push_back('{OP_ALLOC,     6'd0,  32'd0,         32'hFFFF_FFFF, 1'b1,
                       status_word(1'b0, 6'd0)});
      plan.push_back('{OP_ALLOC,     6'd63, 32'd0,         32'd0,         1'b1,
                       status_word(1'b0, 6'd1)});
      // Zero count, and a slot equal to the bank size.
      plan.push_back('{OP_SET_COUNT, 6'd0,  32'd0,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_SET_COUNT, 6'd16, 32'd5,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_SET_COUNT, 6'd0,  32'hFFFF_FFFF, 32'd0,         1'b0, '0});
      plan.push_back('{OP_SET_COUNT, 6'd1,  32'd1,         32'd0,         1'b0, '0});
      plan.push_back('{OP_SET_TAG,   6'd1,  32'd0,         32'hA5A5_5A5A, 1'b0, '0});
      plan.push_back('{OP_SERVICE,   6'd0,  32'd0,         32'd0,         1'b0, '0});
      // Re-arm a counting slot and an expired one.
      plan.push_back('{OP_SET_COUNT, 6'd0,  32'd2,         32'd0,         1'b0, '0});
      plan.push_back('{OP_SET_COUNT, 6'd1,  32'd2,         32'd0,         1'b0, '0});
      plan.push_back('{OP_TICK,      6'd0,  32'd0,         32'd0,         1'b0, '0});
      plan.push_back('{OP_TICK,      6'd0,  32'd0,         32'd0,         1'b0, '0});
      plan.push_back('{OP_SERVICE,   6'd0,  32'd0,         32'd0,         1'b0, '0});
      // Service without pending ticks leaves an armed slot counting.
      plan.push_back('{OP_SET_COUNT, 6'd1,  32'd1,         32'd0,         1'b0, '0});
      plan.push_back('{OP_SERVICE,   6'd0,  32'd0,         32'd0,         1'b0, '0});
      plan.push_back('{OP_FREE,      6'd1,  32'd0,         32'd0,         1'b0, '0});
      plan.push_back('{OP_FREE,      6'd1,  32'd0,         32'd0,         1'b1,
                       status_word(1'b1, 6'd0)});
      plan.push_back('{OP_ALLOC,     6'd0,  32'd0,         32'h1234_5678, 1'b1,
                       status_word(1'b0, 6'd1)});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < plan.size(); i++) begin
         send_word(plan[i].op, plan[i].slot, plan[i].count, plan[i].tag,
                   plan[i].typed, plan[i].want);
      end

      // Random traffic. The accumulator limit of all ones is out of reach here.
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) begin
            steady_phase = ~steady_phase;
         end
         // Now and then let the block drain completely before going on.
         if (n == 0 || n == 150) begin
            req_valid <= 1'b0;
            while (awaited_words.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         // Fill the bank past its size so that allocation runs out.
         if (n == 100) begin
            for (i = 0; i < NUM_TIMERS + 2; i++) begin
               send_word(OP_ALLOC, pick_slot(), pick_count(), $urandom, 1'b0, '0);
            end
         end
         // Sweep every slot with a free, in use or not.
         if (n == 200) begin
            for (i = 0; i < NUM_TIMERS; i++) begin
               send_word(OP_FREE, SLOT_W'(i), pick_count(), $urandom, 1'b0, '0);
            end
         end
         slot  = pick_slot();
         count = pick_count();
         tag   = $urandom;
         r     = $urandom_range(0, 99);
         if (r < 14) begin
            op = OP_ALLOC;
         end else if (r < 24) begin
            op = OP_FREE;
         end else if (r < 48) begin
            op = OP_SET_COUNT;
         end else if (r < 56) begin
            op = OP_SET_TAG;
         end else if (r < 78) begin
            op = OP_TICK;
         end else if (r < 96) begin
            op = OP_SERVICE;
         end else begin
            op = OP_BAD_LO + OP_W'($urandom_range(0, 1));
         end
         send_word(op, slot, count, tag, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SERVICE_CYCLES + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ctb_pkg.sv
src/ctb_cell.sv
src/countdown_timer_bank.sv
bench/tb_countdown_timer_bank.sv
